// ----- src/tqgd_pkg.sv -----
// shared types, constants and codes of the three queue gate dispatcher
package tqgd_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int NUM_QUEUES  = 3;
   localparam int SLOTS       = NUM_QUEUES * QUEUE_DEPTH;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = $clog2(SLOTS);
   localparam int COUNT_W     = 32;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_GATE = 1'b1;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_FULL    = 3'd1,
      ST_SERVED  = 3'd2,
      ST_NONE    = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   typedef logic [1:0] queue_idx_type;

   typedef struct packed {
      logic        opcode;
      logic [1:0]  category;
      logic [1:0]  gate;
      logic [15:0] block;
      logic [15:0] seat;
      logic [63:0] name_chars_0_7;
      logic [63:0] name_chars_8_15;
      logic [23:0] name_chars_16_18;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  served_category;
      logic [15:0] served_block;
      logic [15:0] served_seat;
      logic [63:0] served_name_0_7;
      logic [63:0] served_name_8_15;
      logic [23:0] served_name_16_18;
      logic [31:0] gate_total;
   } rsp_type;

   typedef struct packed {
      logic [15:0] block;
      logic [15:0] seat;
      logic [63:0] name_low;
      logic [63:0] name_mid;
      logic [23:0] name_high;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

// ----- src/tqgd_dpath.sv -----
// datapath: item register, queue pointers, entry memory, gate counts, result register
module tqgd_dpath
   import tqgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BASE_ONE  = ADDR_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_TWO  = ADDR_W'(2 * QUEUE_DEPTH);
   localparam queue_idx_type     Q_SHARED  = 2'd2;
   localparam logic [1:0]        GATE_THREE = 2'd3;

   req_type              item_ff;
   logic [PTR_W-1:0]     head_ff  [NUM_QUEUES];
   logic [PTR_W-1:0]     tail_ff  [NUM_QUEUES];
   logic [FILL_W-1:0]    fill_ff  [NUM_QUEUES];
   logic [COUNT_W-1:0]   count_ff [NUM_QUEUES];
   entry_type            mem      [SLOTS];
   entry_type            rd_data_ff;
   status_type           res_status_ff;
   logic [1:0]           res_cat_ff;
   logic                 res_served_ff;
   logic [COUNT_W-1:0]   res_total_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic                 is_add;
   queue_idx_type        prim;
   queue_idx_type        gidx;
   queue_idx_type        qsel;
   logic [FILL_W-1:0]    prim_fill;
   logic [PTR_W-1:0]     sel_head;
   logic [PTR_W-1:0]     sel_tail;
   logic [FILL_W-1:0]    sel_fill;
   logic [PTR_W-1:0]     sel_ptr;
   logic [ADDR_W-1:0]    base;
   logic [ADDR_W-1:0]    addr;
   logic [COUNT_W-1:0]   cnt_sel;
   logic [COUNT_W-1:0]   cnt_inc;
   logic                 do_push;
   logic                 do_pop;
   status_type           status_in;
   logic [COUNT_W-1:0]   total_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   assign is_add = (item_ff.opcode == OP_ADD);
   assign gidx   = item_ff.gate - 2'd1;
   assign prim   = is_add ? (item_ff.category - 2'd1) : gidx;

   always_comb begin
      unique case (prim)
         2'd0:    prim_fill = fill_ff[0];
         2'd1:    prim_fill = fill_ff[1];
         2'd2:    prim_fill = fill_ff[2];
         default: prim_fill = '0;
      endcase
   end

   // decide what the item does
   always_comb begin
      qsel      = prim;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      status_in = ST_INVALID;
      if (is_add) begin
         priority if (item_ff.category == 2'd0) begin
            status_in = ST_INVALID;
         end else if (prim_fill == FILL_MAX) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_ADDED;
            do_push   = 1'b1;
         end
      end else begin
         priority if (item_ff.gate == 2'd0) begin
            status_in = ST_INVALID;
         end else if (item_ff.gate != GATE_THREE && prim_fill != '0) begin
            status_in = ST_SERVED;
            do_pop    = 1'b1;
         end else if (fill_ff[2] != '0) begin
            // gate 1 and 2 fall back on the shared queue, gate 3 takes only from it
            qsel      = Q_SHARED;
            status_in = ST_SERVED;
            do_pop    = 1'b1;
         end else begin
            status_in = ST_NONE;
         end
      end
   end

   always_comb begin
      unique case (qsel)
         2'd0: begin
            sel_head = head_ff[0];
            sel_tail = tail_ff[0];
            sel_fill = fill_ff[0];
            base     = '0;
         end
         2'd1: begin
            sel_head = head_ff[1];
            sel_tail = tail_ff[1];
            sel_fill = fill_ff[1];
            base     = BASE_ONE;
         end
         default: begin
            sel_head = head_ff[2];
            sel_tail = tail_ff[2];
            sel_fill = fill_ff[2];
            base     = BASE_TWO;
         end
      endcase
   end

   assign sel_ptr = do_push ? sel_tail : sel_head;
   assign addr    = base + ADDR_W'(sel_ptr);

   always_comb begin
      unique case (gidx)
         2'd0:    cnt_sel = count_ff[0];
         2'd1:    cnt_sel = count_ff[1];
         2'd2:    cnt_sel = count_ff[2];
         default: cnt_sel = '0;
      endcase
   end

   // saturating count
   assign cnt_inc = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_W'(1);

   always_comb begin
      priority if (status_in == ST_SERVED) begin
         total_in = cnt_inc;
      end else if (status_in == ST_NONE) begin
         total_in = cnt_sel;
      end else begin
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            if (do_push && qsel == queue_idx_type'(i)) begin
               tail_ff[i] <= next_ptr(sel_tail);
               fill_ff[i] <= sel_fill + FILL_W'(1);
            end
            if (do_pop && qsel == queue_idx_type'(i)) begin
               head_ff[i] <= next_ptr(sel_head);
               fill_ff[i] <= sel_fill - FILL_W'(1);
            end
            if (do_pop && gidx == queue_idx_type'(i)) begin
               count_ff[i] <= cnt_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && do_push) begin
         mem[addr] <= '{block:     item_ff.block,
                        seat:      item_ff.seat,
                        name_low:  item_ff.name_chars_0_7,
                        name_mid:  item_ff.name_chars_8_15,
                        name_high: item_ff.name_chars_16_18};
      end
      if (cmd.execute && do_pop) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         res_status_ff <= status_in;
         res_cat_ff    <= do_pop ? (qsel + 2'd1) : 2'd0;
         res_served_ff <= do_pop;
         res_total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff.status            <= res_status_ff;
         rsp_ff.served_category   <= res_cat_ff;
         rsp_ff.served_block      <= res_served_ff ? rd_data_ff.block     : '0;
         rsp_ff.served_seat       <= res_served_ff ? rd_data_ff.seat      : '0;
         rsp_ff.served_name_0_7   <= res_served_ff ? rd_data_ff.name_low  : '0;
         rsp_ff.served_name_8_15  <= res_served_ff ? rd_data_ff.name_mid  : '0;
         rsp_ff.served_name_16_18 <= res_served_ff ? rd_data_ff.name_high : '0;
         rsp_ff.gate_total        <= res_total_ff;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ----- src/tqgd_ctrl.sv -----
// controller: sequences capture, execute and result load of one item
module tqgd_ctrl
   import tqgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_valid && !req_stall_ff;
      cmd.execute = (state_ff == S_EXEC);
      cmd.load    = (state_ff == S_LOAD) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.capture) begin
                  state_ff     <= S_EXEC;
                  req_stall_ff <= 1'b1;
               end
            end
            S_EXEC: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (sts.out_free) begin
                  state_ff     <= S_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// ----- src/three_queue_gate_dispatcher.sv -----
// top level of the three queue gate dispatcher
//
// usage
//   req channel: one item per transfer, either an add (entry goes to the
//   tail of queue 1, 2 or 3) or a gate request (gate 1 or 2 takes from its
//   own queue and falls back on queue 3, gate 3 takes only from queue 3)
//   rsp channel: exactly one result per item, in item order, with status,
//   the served entry and the gate's saturating served total
// sequencing
//   each item runs through capture, execute (with the single entry memory
//   access) and result load, registered in that order; no new item is
//   taken before the result of the last one has been loaded
//   req_stall is high from the transfer until the result has been loaded
// reset
//   synchronous, active high; all queues empty and all gate totals zero
//   right away, no clearing pass, entry memory is not cleared
// receiver stall
//   a result held by rsp_stall stays in the output register; the next item
//   is still taken and processed, and waits for the register to free up
module three_queue_gate_dispatcher
   import tqgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer for one item at a time
   tqgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // queues, entry memory, gate totals and output register
   tqgd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // one item in flight: a transfer closes the req channel
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken while an item is in flight");

   // a served entry always names its queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SERVED |-> rsp_data.served_category != 2'd0)
      else $error("served result without a queue");

   // nothing served means no queue named
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_SERVED |-> rsp_data.served_category == 2'd0)
      else $error("queue named on a result that served nothing");

   // adds and invalid items carry no gate total
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_ADDED || rsp_data.status == ST_FULL ||
                    rsp_data.status == ST_INVALID) |-> rsp_data.gate_total == 32'd0)
      else $error("gate total on a result without a gate");

endmodule
